// ===== design/sdpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Short-descriptor page walk package
// Item types, configuration layout, codes and the RAM window check.
// ----------------------------------------------------------------------------
package sdpw_pkg;

   typedef enum logic [1:0] {
      CSR_TABLE_BASE_ZERO = 2'd0,
      CSR_TABLE_BASE_ONE  = 2'd1,
      CSR_SPLIT_BITS      = 2'd2,
      CSR_MMU_PRESENT     = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_TRANSLATE = 1'b0,
      REQ_READ_RESP = 1'b1
   } req_kind_type;

   typedef enum logic {
      RESULT_READ_REQ = 1'b0,
      RESULT_DONE     = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE     = 2'd0,
      FAULT_INVALID  = 2'd1,
      FAULT_NOT_RAM  = 2'd2,
      FAULT_NO_MMU   = 2'd3
   } fault_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] virt_addr;
      logic [31:0] read_data;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] read_addr;
      logic [31:0] phys_addr;
      logic [1:0]  fault;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] table_base_zero;
      logic [31:0] table_base_one;
      logic [2:0]  split_bits;
      logic        mmu_present;
   } cfg_type;

   localparam int unsigned NUM_WINDOWS = 4;

   localparam logic [31:0] WIN_START [NUM_WINDOWS] = '{
      32'h0800_0000, 32'h1800_0000, 32'h1FF0_0000, 32'h2000_0000
   };
   localparam logic [32:0] WIN_END [NUM_WINDOWS] = '{
      33'h0_0818_0000, 33'h0_1860_0000, 33'h0_2000_0000, 33'h0_3000_0000
   };

   // A descriptor word must fit entirely inside one of the RAM windows.
   function automatic logic in_ram(input logic [31:0] addr);
      logic        hit;
      logic [32:0] addr_end;
      hit      = 1'b0;
      addr_end = {1'b0, addr} + 33'd4;
      for (int i = 0; i < NUM_WINDOWS; i++) begin
         if (addr >= WIN_START[i] && {1'b0, addr} < WIN_END[i] &&
             addr_end <= WIN_END[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ===== design/sdpw_csr.sv =====
// ----------------------------------------------------------------------------
// Short-descriptor page walk configuration registers
// Holds the table bases, split width and MMU presence flag.
// ----------------------------------------------------------------------------
module sdpw_csr import sdpw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TABLE_BASE_ZERO: cfg_in.table_base_zero = csr_wdata;
            CSR_TABLE_BASE_ONE:  cfg_in.table_base_one  = csr_wdata;
            CSR_SPLIT_BITS:      cfg_in.split_bits      = csr_wdata[2:0];
            CSR_MMU_PRESENT:     cfg_in.mmu_present     = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_base_zero <= '0;
         cfg_ff.table_base_one  <= '0;
         cfg_ff.split_bits      <= '0;
         cfg_ff.mmu_present     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/sdpw_in_stage.sv =====
// ----------------------------------------------------------------------------
// Short-descriptor page walk input register
// Captures one item and holds it until the walker takes it.
// ----------------------------------------------------------------------------
module sdpw_in_stage import sdpw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         take,
   output logic         held_valid,
   output req_item_type held_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // Stall only while a held item cannot move on this cycle.
   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== design/sdpw_core.sv =====
// ----------------------------------------------------------------------------
// Short-descriptor page walk core
// Decodes one item against the walk state and registers the result item.
// ----------------------------------------------------------------------------
module sdpw_core import sdpw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         held_valid,
   input  req_item_type held_item,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_L1   = 2'd1,
      PHASE_L2   = 2'd2
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [31:0]  held_vaddr_ff, held_vaddr_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type res;
   logic         res_valid;
   logic         out_free;

   logic [6:0]   split_mask;
   logic [31:0]  base;
   logic [31:0]  l1_addr;
   logic [31:0]  l2_addr;
   logic [31:0]  data;
   logic [31:0]  vaddr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = held_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign data      = held_item.read_data;
   assign vaddr     = held_item.virt_addr;

   // Bit i covers virt_addr[25+i]; the top split_bits bits are selected.
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         split_mask[i] = ({1'b0, cfg.split_bits} + 4'(i)) >= 4'd7;
      end
   end

   assign base    = (|(vaddr[31:25] & split_mask)) ? cfg.table_base_one
                                                   : cfg.table_base_zero;
   assign l1_addr = {base[31:14], vaddr[31:20], 2'b00};
   assign l2_addr = {data[31:10], held_vaddr_ff[19:12], 2'b00};

   always_comb begin
      phase_in      = phase_ff;
      held_vaddr_in = held_vaddr_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (take) begin
         if (held_item.req_type == REQ_TRANSLATE) begin
            res_valid = 1'b1;
            if (!cfg.mmu_present) begin
               res.result_kind = RESULT_DONE;
               res.fault       = FAULT_NO_MMU;
               phase_in        = PHASE_IDLE;
            end else if (!in_ram(l1_addr)) begin
               res.result_kind = RESULT_DONE;
               res.fault       = FAULT_NOT_RAM;
               phase_in        = PHASE_IDLE;
            end else begin
               res.result_kind = RESULT_READ_REQ;
               res.read_addr   = l1_addr;
               held_vaddr_in   = vaddr;
               phase_in        = PHASE_L1;
            end
         end else begin
            case (phase_ff)
               PHASE_L1: begin
                  res_valid       = 1'b1;
                  res.result_kind = RESULT_DONE;
                  phase_in        = PHASE_IDLE;
                  case (data[1:0])
                     2'b10: begin
                        if (data[18]) begin
                           res.phys_addr = {data[31:24], held_vaddr_ff[23:0]};
                        end else begin
                           res.phys_addr = {data[31:20], held_vaddr_ff[19:0]};
                        end
                     end
                     2'b01: begin
                        if (in_ram(l2_addr)) begin
                           res.result_kind = RESULT_READ_REQ;
                           res.read_addr   = l2_addr;
                           phase_in        = PHASE_L2;
                        end else begin
                           res.fault = FAULT_NOT_RAM;
                        end
                     end
                     default: res.fault = FAULT_INVALID;
                  endcase
               end
               PHASE_L2: begin
                  res_valid       = 1'b1;
                  res.result_kind = RESULT_DONE;
                  phase_in        = PHASE_IDLE;
                  case (data[1:0])
                     2'b01:   res.phys_addr = {data[31:16], held_vaddr_ff[15:0]};
                     2'b10,
                     2'b11:   res.phys_addr = {data[31:12], held_vaddr_ff[11:0]};
                     default: res.fault     = FAULT_INVALID;
                  endcase
               end
               default: begin
                  // A response with no walk pending is dropped.
                  phase_in = PHASE_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (take) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         held_vaddr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         held_vaddr_ff <= held_vaddr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         rsp_item_ff <= res;
      end
   end

endmodule

// ===== design/short_descriptor_page_walk_top.sv =====
// ----------------------------------------------------------------------------
// Short-descriptor page walk top level
// Two-level translation table walker with configuration registers.
// ----------------------------------------------------------------------------
// Each req_ item is either a translate request or the descriptor word that
// memory returns for the walker's last read request; each rsp_ item is a new
// descriptor read request or a finished translation with its fault code. An
// item passes through one input register and one result register, so its
// result is offered on rsp_ once it has moved through both registers, and
// one item can be accepted in every cycle while results are taken. While a
// result waits under rsp_stall, the item in the input register waits behind
// it and req_stall is raised in that same cycle. The walk state updates as
// the item moves from the input register to the result register. A response
// that arrives with no walk pending gives no result. Configuration writes are
// always ready and should be made only while no walk is in progress.
module short_descriptor_page_walk_top import sdpw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   cfg_type      cfg;
   logic         held_valid;
   req_item_type held_item;
   logic         take;

   sdpw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdpw_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   sdpw_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .held_valid (held_valid),
      .held_item  (held_item),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule
